// ===== design/apmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmh_pkg - shared types and constants of the hamming pattern matcher
// Widths, register map codes and the item formats that pass between the
// front end, the queue and the counting back end.
// ----------------------------------------------------------------------------
package apmh_pkg;

  localparam int MAX_PATTERN_LEN = 64;
  localparam int POSITION_WIDTH  = 32;
  localparam int LEN_W           = 7;
  localparam int OUT_POS_W       = 32;
  localparam int CNT_W           = 7;
  localparam int APB_DATA_W      = 64;
  localparam int APB_ADDR_W      = 5;

  // register indexes, at byte address 8 * index
  typedef enum logic [1:0] {
    REG_PATTERN_BITS   = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_MISMATCH_LIMIT = 2'd2
  } reg_index_t;

  localparam logic [MAX_PATTERN_LEN-1:0] PATTERN_RESET = '0;
  localparam logic [LEN_W-1:0]           LENGTH_RESET  = LEN_W'(10);
  localparam logic [LEN_W-1:0]           LIMIT_RESET   = LEN_W'(2);

  // live settings seen by the datapath
  typedef struct packed {
    logic [MAX_PATTERN_LEN-1:0] pattern;
    logic [LEN_W-1:0]           length;   // already clamped to 1..64
    logic [LEN_W-1:0]           limit;
  } match_cfg_t;

  // one full window waiting to be scored
  typedef struct packed {
    logic [MAX_PATTERN_LEN-1:0] window;
    logic [OUT_POS_W-1:0]       position;
  } window_req_t;

  // clamp a programmed length into 1..MAX_PATTERN_LEN
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MAX_PATTERN_LEN)) begin
      res = LEN_W'(MAX_PATTERN_LEN);
    end
    return res;
  endfunction

endpackage

// ===== design/apmh_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmh_fifo - two-entry request queue
// Decouples the window front end from the counting back end so that either
// side may stall without holding up the other.
// ----------------------------------------------------------------------------
module apmh_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  apmh_pkg::window_req_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop,
  output apmh_pkg::window_req_t pop_data
);
  import apmh_pkg::*;

  window_req_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/apmh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmh_front - reference bit intake
// Shifts each accepted bit into the window, counts bits since the last
// start and queues a scoring request once the window holds a full pattern.
// ----------------------------------------------------------------------------
module apmh_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       ref_bit,
  input  logic                       start_req,
  input  logic [apmh_pkg::LEN_W-1:0] length,
  output logic                       push,
  output apmh_pkg::window_req_t      push_data,
  input  logic                       q_full
);
  import apmh_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [MAX_PATTERN_LEN-1:0] window;
  logic [POSITION_WIDTH-1:0]  bits_seen;
  logic [MAX_PATTERN_LEN-1:0] window_base;
  logic [POSITION_WIDTH-1:0]  seen_base;
  logic [MAX_PATTERN_LEN-1:0] window_next;
  logic [POSITION_WIDTH-1:0]  bits_seen_next;
  logic [POSITION_WIDTH-1:0]  start_pos;
  logic                       accept;
  logic                       full_window;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // next window and saturating bit count
  always_comb begin
    window_base    = start_req ? '0 : window;
    seen_base      = start_req ? '0 : bits_seen;
    window_next    = {window_base[MAX_PATTERN_LEN-2:0], ref_bit};
    bits_seen_next = (seen_base == POS_MAX) ? seen_base : seen_base + POSITION_WIDTH'(1);
    full_window    = (bits_seen_next >= POSITION_WIDTH'(length));
    start_pos      = bits_seen_next - POSITION_WIDTH'(length);
  end

  // request to the back end
  assign push               = accept && full_window;
  assign push_data.window   = window_next;
  assign push_data.position = OUT_POS_W'(start_pos);

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      bits_seen <= '0;
    end else if (accept) begin
      window    <= window_next;
      bits_seen <= bits_seen_next;
    end
  end

endmodule

// ===== design/apmh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmh_back - mismatch counter
// Three stages: aligned difference vector, byte population counts, then
// the final sum, limit compare and the result register.
// ----------------------------------------------------------------------------
module apmh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  apmh_pkg::match_cfg_t      cfg,
  input  logic                      req_valid,
  output logic                      req_pop,
  input  apmh_pkg::window_req_t     req_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [apmh_pkg::OUT_POS_W-1:0] out_position,
  output logic [apmh_pkg::CNT_W-1:0]     out_count
);
  import apmh_pkg::*;

  localparam int NUM_BYTES = MAX_PATTERN_LEN / 8;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

  logic [MAX_PATTERN_LEN-1:0] rev_pattern;
  logic [MAX_PATTERN_LEN-1:0] aligned_pattern;
  logic [MAX_PATTERN_LEN-1:0] len_mask;
  logic [LEN_W-1:0]           shift_amt;

  logic                       a_valid;
  logic [MAX_PATTERN_LEN-1:0] a_diff;
  logic [OUT_POS_W-1:0]       a_pos;
  logic                       b_valid;
  logic [3:0]                 b_part [NUM_BYTES];
  logic [OUT_POS_W-1:0]       b_pos;
  logic [CNT_W-1:0]           c_sum;

  logic a_ready;
  logic b_ready;
  logic c_ready;

  // stall chain from the result register backwards
  assign c_ready = !out_valid || out_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign req_pop = req_valid && a_ready;

  // pattern element j meets window bit len-1-j: reverse, then shift down
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      rev_pattern[i] = cfg.pattern[MAX_PATTERN_LEN-1-i];
    end
    shift_amt       = LEN_W'(MAX_PATTERN_LEN) - cfg.length;
    aligned_pattern = rev_pattern >> shift_amt;
    len_mask        = ~({MAX_PATTERN_LEN{1'b1}} << cfg.length);
  end

  // stage a: difference vector
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req_valid) begin
      a_diff <= (req_data.window ^ aligned_pattern) & len_mask;
      a_pos  <= req_data.position;
    end
  end

  // stage b: per-byte counts
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      for (int k = 0; k < NUM_BYTES; k++) begin
        b_part[k] <= popcount8(a_diff[8*k +: 8]);
      end
      b_pos <= a_pos;
    end
  end

  // final sum
  always_comb begin
    c_sum = '0;
    for (int k = 0; k < NUM_BYTES; k++) begin
      c_sum = c_sum + CNT_W'(b_part[k]);
    end
  end

  // stage c: result register, valid only for windows within the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid && (c_sum <= cfg.limit);
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      out_position <= b_pos;
      out_count    <= c_sum;
    end
  end

endmodule

// ===== design/approx_pattern_match_hamming_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approx_pattern_match_hamming_core - k-mismatch binary pattern matcher
//
//   port group   dir   fields (low bit first)
//   s_axis       in    tdata: ref_bit, 7 zero bits; tuser: start_req
//   m_axis       out   tdata: match_position[31:0], mismatch_count[6:0], 0
//   apb          cfg   0x00 pattern_bits, 0x08 pattern_length,
//                      0x10 mismatch_limit
//
// One reference bit is taken every cycle while the queue is not full; the window
// shift and the queue push sit in the same cycle at the front.
// A taken bit's result passes through the queue and then the difference,
// byte count and sum stages of the back end.
// Reset is synchronous; it clears window, bit count, queue and stages and restores the settings.
// The two-entry queue lets intake keep running while a result stalls; the
// input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module approx_pattern_match_hamming_core (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // ref_bit, pad
  input  logic [0:0]                          s_axis_tuser,  // start_req
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [39:0]                         m_axis_tdata,  // match_position, mismatch_count, pad
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [apmh_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [apmh_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [apmh_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import apmh_pkg::*;

  logic [MAX_PATTERN_LEN-1:0] pattern_bits;
  logic [LEN_W-1:0]           pattern_length;
  logic [LEN_W-1:0]           mismatch_limit;
  reg_index_t                 reg_sel;
  logic                       cfg_write;
  match_cfg_t                 cfg;

  logic                       q_push;
  window_req_t                q_push_data;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  window_req_t                q_pop_data;
  logic [OUT_POS_W-1:0]       res_position;
  logic [CNT_W-1:0]           res_count;

  // register file
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[APB_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= PATTERN_RESET;
      pattern_length <= LENGTH_RESET;
      mismatch_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_PATTERN_BITS:   pattern_bits   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        REG_MISMATCH_LIMIT: mismatch_limit <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BITS:   prdata = pattern_bits;
      REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length);
      REG_MISMATCH_LIMIT: prdata = APB_DATA_W'(mismatch_limit);
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern = pattern_bits;
  assign cfg.length  = eff_length(pattern_length);
  assign cfg.limit   = mismatch_limit;

  // intake
  apmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .ref_bit   (s_axis_tdata[0]),
    .start_req (s_axis_tuser[0]),
    .length    (cfg.length),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  // request queue
  apmh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_pop_data)
  );

  // scoring
  apmh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req_valid    (q_valid),
    .req_pop      (q_pop),
    .req_data     (q_pop_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (res_position),
    .out_count    (res_count)
  );

  assign m_axis_tdata = {1'b0, res_count, res_position};

endmodule

// ===== design/apmh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apmh_checker - port-level checks for the pattern matcher
// Watches the top level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module apmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);

  // a stalled result is not withdrawn
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // no result straight out of reset
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

  // a count never exceeds the widest pattern, pad bit stays clear
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[38:32] <= 7'd64) && !m_axis_tdata[39])
    else $error("mismatch count out of range");

  // configuration port never waits
  assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind approx_pattern_match_hamming_core apmh_checker u_apmh_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the hamming k-mismatch pattern matcher
// Streams reference bits with random gaps on both sides and scores every
// accepted request with its own window model. Each result is compared with
// the oldest expected match. Settings change over the APB port between
// phases and are read back after each write to a mapped register.
// ----------------------------------------------------------------------------
module tb;
  import apmh_pkg::*;

  localparam int         HOLD_CYCLES  = 200;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         RANDOM_BITS  = 850;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_HIT} exp_kind_t;
  typedef enum logic {ROW_BIT, ROW_CFG} row_kind_t;

  typedef struct {
    logic        ref_bit;
    logic        start;
    exp_kind_t   exp;
    logic [31:0] pos;
    logic [6:0]  cnt;
  } bit_req_t;

  typedef struct {
    logic [31:0] pos;
    logic [6:0]  cnt;
  } match_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    bit_req_t    req;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // ref_bit, 7 zero bits
  logic [0:0]            s_axis_tuser;   // start_req
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;   // match_position[31:0], mismatch_count[6:0], 0
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // bench state
  bit_req_t  bit_q[$];
  match_t    match_q[$];
  stim_row_t dir_tab[$];
  bit        tx_busy  = 1'b0;
  bit        tx_gaps  = 1'b1;
  bit        rx_gaps  = 1'b1;
  bit        hold_req = 1'b0;
  int        fail_cnt = 0;

  // window model
  logic [63:0] mdl_pattern = 64'd0;
  logic [6:0]  mdl_length  = 7'd10;
  logic [6:0]  mdl_limit   = 7'd2;
  logic [63:0] mdl_window  = 64'd0;
  logic [31:0] mdl_seen    = 32'd0;

  approx_pattern_match_hamming_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // safety net
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // zero acts as one, anything past the window size is cut to it
  function automatic int clamp_len(input logic [6:0] l);
    int n;
    n = int'(l);
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_PATTERN_LEN) begin
      n = MAX_PATTERN_LEN;
    end
    return n;
  endfunction

  function automatic stim_row_t bit_row(input logic b, input logic st, input exp_kind_t e,
                                        input logic [31:0] pos, input logic [6:0] cnt);
    stim_row_t row;
    row.kind        = ROW_BIT;
    row.reg_idx     = REG_UNUSED;
    row.value       = '0;
    row.req.ref_bit = b;
    row.req.start   = st;
    row.req.exp     = e;
    row.req.pos     = pos;
    row.req.cnt     = cnt;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [63:0] value);
    stim_row_t row;
    row         = bit_row(1'b0, 1'b0, EXP_NONE, '0, '0);
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = value;
    return row;
  endfunction

  // queue tails
  function automatic void add_bit(input bit_req_t r);
    bit_q.insert(bit_q.size(), r);
  endfunction

  function automatic void add_match(input match_t r);
    match_q.insert(match_q.size(), r);
  endfunction

  function automatic void add_row(input stim_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic bit all_idle();
    return bit_q.size() == 0 && !tx_busy && match_q.size() == 0;
  endfunction

  // shift one bit into the window and score the last len bits
  task automatic score_bit(input logic b, input logic st, output logic hit, output match_t m);
    int len;
    int errs;
    int j;
    len  = clamp_len(mdl_length);
    errs = 0;
    hit  = 1'b0;
    m.pos = '0;
    m.cnt = '0;
    if (st) begin
      mdl_window = '0;
      mdl_seen   = '0;
    end
    mdl_window = {mdl_window[62:0], b};
    if (mdl_seen != '1) begin
      mdl_seen = mdl_seen + 32'd1;
    end
    if (mdl_seen >= 32'(len)) begin
      // window element j is the bit len-1-j places back from the newest
      for (j = 0; j < len; j++) begin
        errs += int'(mdl_window[len-1-j] ^ mdl_pattern[j]);
      end
      if (errs <= int'(mdl_limit)) begin
        hit   = 1'b1;
        m.pos = mdl_seen - 32'(len);
        m.cnt = 7'(errs);
      end
    end
  endtask

  task automatic queue_bit(input logic b, input logic st);
    stim_row_t row;
    row = bit_row(b, st, EXP_MODEL, '0, '0);
    add_bit(row.req);
  endtask

  // register write once the pipe has drained, then read back if the index is mapped
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] want;
    reg_index_t  name_idx;
    while (!all_idle()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_PATTERN_BITS:   mdl_pattern = value;
      REG_PATTERN_LENGTH: mdl_length  = value[6:0];
      REG_MISMATCH_LIMIT: mdl_limit   = value[6:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      name_idx = reg_index_t'(idx);
      want = (idx == REG_PATTERN_BITS)   ? mdl_pattern :
             (idx == REG_PATTERN_LENGTH) ? 64'(mdl_length) : 64'(mdl_limit);
      if (prdata !== want) begin
        $error("%s readback: expected %h, got %h", name_idx.name(), want, prdata);
        fail_cnt++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender: one request per bit, random gap before each while tx_gaps is set
  initial begin : sender
    bit_req_t cur;
    match_t   m;
    logic     hit;
    int       gap;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (bit_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        cur     = bit_q.pop_front();
        tx_busy = 1'b1;
        gap     = tx_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cur.ref_bit};
        s_axis_tuser  <= cur.start;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        score_bit(cur.ref_bit, cur.start, hit, m);
        case (cur.exp)
          EXP_MODEL: begin
            if (hit) add_match(m);
          end
          EXP_HIT: begin
            m.pos = cur.pos;
            m.cnt = cur.cnt;
            add_match(m);
          end
          default: ;
        endcase
        tx_busy = 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  // result check against the oldest expected match
  always @(posedge clk) begin
    match_t want;
    if (rst === 1'b0 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (match_q.size() == 0) begin
        $error("unexpected result: match_position %0d, mismatch_count %0d",
               m_axis_tdata[31:0], m_axis_tdata[38:32]);
        fail_cnt++;
      end else begin
        want = match_q.pop_front();
        if (m_axis_tdata[31:0] !== want.pos) begin
          $error("match_position: expected %0d, got %0d", want.pos, m_axis_tdata[31:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[38:32] !== want.cnt) begin
          $error("mismatch_count: expected %0d, got %0d", want.cnt, m_axis_tdata[38:32]);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : main
    stim_row_t   row;
    logic [63:0] pat_val;
    logic [63:0] flips;
    logic [6:0]  len_val;
    logic [6:0]  lim_val;
    logic        first_start;
    int          eff;
    int          sel;
    int          n;
    int          cnt;
    int          phase;
    int          rand_bits;
    int          i;
    int          j;

    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset settings: pattern all zeros, length 10, limit 2
    add_row(bit_row(1'b0, 1'b1, EXP_NONE, '0, '0));
    for (i = 0; i < 8; i++) begin
      add_row(bit_row(1'b0, 1'b0, EXP_NONE, '0, '0));
    end
    // window just full, then one and two mismatches, then over the limit
    add_row(bit_row(1'b0, 1'b0, EXP_HIT, 32'd0, 7'd0));
    add_row(bit_row(1'b1, 1'b0, EXP_HIT, 32'd1, 7'd1));
    add_row(bit_row(1'b1, 1'b0, EXP_HIT, 32'd2, 7'd2));
    add_row(bit_row(1'b1, 1'b0, EXP_NONE, '0, '0));
    // length zero acts as one, applied mid-stream, exact match only
    add_row(cfg_row(REG_PATTERN_BITS, '1));
    add_row(cfg_row(REG_PATTERN_LENGTH, 64'd0));
    add_row(cfg_row(REG_MISMATCH_LIMIT, 64'd0));
    add_row(bit_row(1'b1, 1'b0, EXP_HIT, 32'd13, 7'd0));
    add_row(bit_row(1'b0, 1'b0, EXP_NONE, '0, '0));
    // write to an unmapped index must leave everything alone
    add_row(cfg_row(REG_UNUSED, '1));
    add_row(bit_row(1'b1, 1'b0, EXP_HIT, 32'd15, 7'd0));
    add_row(bit_row(1'b0, 1'b0, EXP_NONE, '0, '0));
    // oversized length acts as the full window
    add_row(cfg_row(REG_PATTERN_LENGTH, 64'd127));
    add_row(cfg_row(REG_MISMATCH_LIMIT, 64'd127));
    add_row(bit_row(1'b1, 1'b1, EXP_NONE, '0, '0));
    add_row(bit_row(1'b0, 1'b0, EXP_NONE, '0, '0));
    // short length with a limit past it reports every position
    add_row(cfg_row(REG_PATTERN_LENGTH, 64'd2));
    add_row(bit_row(1'b1, 1'b0, EXP_MODEL, '0, '0));
    add_row(bit_row(1'b0, 1'b0, EXP_MODEL, '0, '0));
    add_row(bit_row(1'b1, 1'b1, EXP_MODEL, '0, '0));
    add_row(bit_row(1'b1, 1'b0, EXP_MODEL, '0, '0));
    add_row(bit_row(1'b0, 1'b0, EXP_MODEL, '0, '0));

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        add_bit(row.req);
      end
    end

    // random phases: fresh settings, then pattern copies and noise
    phase     = 0;
    rand_bits = 0;
    while (rand_bits < RANDOM_BITS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       len_val = 7'd0;
        1:       len_val = 7'd1;
        2:       len_val = 7'd64;
        3:       len_val = ($urandom_range(0, 1) != 0) ? 7'd65 : 7'd127;
        default: len_val = 7'($urandom_range(2, 16));
      endcase
      eff = clamp_len(len_val);
      sel = $urandom_range(0, 7);
      case (sel)
        0:       lim_val = 7'd0;
        1:       lim_val = 7'd127;
        2:       lim_val = 7'd64;
        3:       lim_val = 7'(eff);
        default: lim_val = 7'($urandom_range(0, eff / 4 + 1));
      endcase
      sel = $urandom_range(0, 5);
      case (sel)
        0:       pat_val = '0;
        1:       pat_val = '1;
        default: pat_val = {$urandom, $urandom};
      endcase
      // pressure phase: every position reports while the receiver holds off
      if (phase == 2) begin
        len_val = 7'd4;
        eff     = 4;
        lim_val = 7'd127;
      end

      write_reg(REG_PATTERN_BITS, pat_val);
      write_reg(REG_PATTERN_LENGTH, {$urandom, 25'($urandom), len_val});
      write_reg(REG_MISMATCH_LIMIT, {$urandom, 25'($urandom), lim_val});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, {$urandom, $urandom});
      end

      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
      end

      n           = 2 * eff + $urandom_range(40, 100);
      first_start = $urandom_range(0, 3) != 0;
      cnt         = 0;
      while (cnt < n) begin
        if ($urandom_range(0, 3) != 0) begin
          // copy of the pattern, oldest element first, with a few flips
          flips = '0;
          repeat ($urandom_range(0, 3)) flips[$urandom_range(0, eff - 1)] = 1'b1;
          for (j = 0; j < eff; j++) begin
            queue_bit(pat_val[j] ^ flips[j], first_start);
            first_start = 1'b0;
            cnt++;
          end
        end else begin
          // noise with the odd restart
          repeat ($urandom_range(1, 8)) begin
            queue_bit(1'($urandom_range(0, 1)),
                      first_start || ($urandom_range(0, 29) == 0));
            first_start = 1'b0;
            cnt++;
          end
        end
      end
      rand_bits += cnt;
      phase++;
    end

    while (!all_idle()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/apmh_pkg.sv
design/apmh_fifo.sv
design/apmh_front.sv
design/apmh_back.sv
design/approx_pattern_match_hamming_core.sv
design/apmh_checker.sv
tb/sv/tb.sv
